### rtl/micv_pkg.sv
package micv_pkg;

   localparam int MAX_DISP         = 63;
   localparam int INTENSITY_LEVELS = 256;
   localparam int SCORE_FRAC_BITS  = 12;

   localparam int LEVEL_BITS    = $clog2(INTENSITY_LEVELS);
   localparam int TABLE_DEPTH   = 1 << (2 * LEVEL_BITS);
   localparam int TABLE_COUNT   = 3;
   localparam int STORE_DEPTH   = MAX_DISP + 1;
   localparam int STORE_BITS    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int STORE_WIDTH   = 3 * LEVEL_BITS;
   localparam int COL_BITS      = $clog2(STORE_DEPTH + 1);

   localparam int SCORE_BITS    = 17;
   localparam int SUM_BITS      = SCORE_BITS + 2;
   localparam int COST_SCALE    = 1000;
   localparam int SCALE_BITS    = 10;
   localparam int PROD_BITS     = SUM_BITS + SCALE_BITS;
   localparam int SHIFT_BITS    = PROD_BITS - SCORE_FRAC_BITS;
   localparam int COST_BITS     = 16;
   localparam int COST_MAX      = 65535;
   localparam int DISP_BITS     = 6;
   localparam int CSR_DATA_BITS = 16;
   localparam int CSR_INDEX_BITS = 1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_DISPARITY = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BORDER_COST   = 1'd1;

   localparam logic FUNC_TABLE_WRITE = 1'b0;
   localparam logic FUNC_PIXEL       = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [1:0]            table_channel;
      logic [7:0]            table_right_level;
      logic [7:0]            table_left_level;
      logic [SCORE_BITS-1:0] score_value;
      logic [7:0]            left_red;
      logic [7:0]            left_green;
      logic [7:0]            left_blue;
      logic [7:0]            right_red;
      logic [7:0]            right_green;
      logic [7:0]            right_blue;
      logic                  row_start;
   } req_type;

   typedef struct packed {
      logic [COST_BITS-1:0] cost;
      logic [DISP_BITS-1:0] disparity;
      logic                 last_of_pixel;
   } rsp_type;

   function automatic logic [LEVEL_BITS-1:0] clamp_level(input logic [7:0] v);
      logic [LEVEL_BITS-1:0] r;
      if (32'(v) >= INTENSITY_LEVELS) begin
         r = LEVEL_BITS'(INTENSITY_LEVELS - 1);
      end else begin
         r = LEVEL_BITS'(v);
      end
      return r;
   endfunction

endpackage

### rtl/mutual_info_cost_volume_core.sv
// Stereo matching cost volume, left image as reference.
// req channel (valid/ready) carries one item per transfer. A table write item
// (func 0) stores one score entry in the red, green or blue table (channel 3
// stores nothing) and yields no result. A pixel item (func 1) pushes the right
// pixel into the line store and yields max_disparity+1 cost items on the rsp
// channel, disparity 0 first, last_of_pixel set on the final one.
// Each cost goes through the states LREAD (line store read), TREAD (table
// read), MUL (sum and multiply by 1000) and SAT (shift and saturate) to OUT,
// where rsp_valid is high; a border cost skips the tables and goes from LREAD
// straight to OUT. The next disparity starts once the result is taken. The
// line store and score table reads are registered and chained. req_ready is
// low for the whole pixel. If the receiver stalls, the pending cost holds in
// the output register and the sequence waits. csr port writes max_disparity
// (index 0) and border_cost (index 1); the user must do so only while idle;
// the block itself does not enforce it. Reset (synchronous) returns to idle,
// sets max_disparity 63, border_cost 0, clears the column count and line
// store position. Score tables and line store are not cleared.
module mutual_info_cost_volume_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  micv_pkg::req_type                     req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output micv_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_wr_en,
   input  logic [micv_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [micv_pkg::CSR_DATA_BITS-1:0]    csr_wr_data
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_LREAD = 3'd1;
   localparam logic [2:0] ST_TREAD = 3'd2;
   localparam logic [2:0] ST_MUL   = 3'd3;
   localparam logic [2:0] ST_SAT   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   localparam int LB = micv_pkg::LEVEL_BITS;

   logic [2:0]                          state_ff, state_in;
   logic [micv_pkg::DISP_BITS-1:0]      max_disparity_ff, max_disparity_in;
   logic [micv_pkg::COST_BITS-1:0]      border_cost_ff, border_cost_in;
   logic [micv_pkg::DISP_BITS-1:0]      disp_ff, disp_in;
   logic [micv_pkg::DISP_BITS-1:0]      maxd_ff, maxd_in;
   logic [micv_pkg::COL_BITS-1:0]       x_ff, x_in;
   logic [micv_pkg::COL_BITS-1:0]       col_count_ff, col_count_in;
   logic [micv_pkg::STORE_BITS-1:0]     store_pos_ff, store_pos_in;
   logic [3*LB-1:0]                     left_ff, left_in;
   logic [micv_pkg::PROD_BITS-1:0]      product_ff, product_in;
   micv_pkg::rsp_type                   rsp_data_ff, rsp_data_in;

   logic                                req_accept;
   logic                                rsp_accept;
   logic [micv_pkg::COL_BITS-1:0]       col_start;
   logic [micv_pkg::STORE_BITS-1:0]     slot;
   logic                                ls_wr_en;
   logic                                ls_rd_en;
   logic [micv_pkg::STORE_WIDTH-1:0]    ls_wr_data;
   logic [micv_pkg::STORE_WIDTH-1:0]    ls_rd_data;
   logic [micv_pkg::TABLE_COUNT-1:0]    tbl_wr_en;
   logic [2*LB-1:0]                     tbl_wr_addr;
   logic                                tbl_rd_en;
   logic [2*LB-1:0]                     tbl_rd_addr [micv_pkg::TABLE_COUNT];
   logic [micv_pkg::SCORE_BITS-1:0]     tbl_rd_data [micv_pkg::TABLE_COUNT];
   logic [micv_pkg::SUM_BITS-1:0]       score_sum;
   logic [micv_pkg::SHIFT_BITS-1:0]     scaled;
   logic [micv_pkg::COST_BITS-1:0]      cost_sat;
   logic                                table_write_ok;

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_OUT);
   assign rsp_data   = rsp_data_ff;
   assign req_accept = req_valid && req_ready;
   assign rsp_accept = rsp_valid && rsp_ready;

   assign col_start = req_data.row_start ? '0 : col_count_ff;

   assign table_write_ok = req_accept && (req_data.func == micv_pkg::FUNC_TABLE_WRITE) &&
                           (req_data.table_channel < 2'd3) &&
                           (32'(req_data.table_right_level) < micv_pkg::INTENSITY_LEVELS) &&
                           (32'(req_data.table_left_level) < micv_pkg::INTENSITY_LEVELS);

   assign tbl_wr_addr = {LB'(req_data.table_right_level), LB'(req_data.table_left_level)};

   always_comb begin
      for (int c = 0; c < micv_pkg::TABLE_COUNT; c++) begin
         tbl_wr_en[c] = table_write_ok && (32'(req_data.table_channel) == c);
      end
   end

   assign ls_wr_en   = req_accept && (req_data.func == micv_pkg::FUNC_PIXEL);
   assign ls_wr_data = {micv_pkg::clamp_level(req_data.right_red),
                        micv_pkg::clamp_level(req_data.right_green),
                        micv_pkg::clamp_level(req_data.right_blue)};

   always_comb begin
      if (32'(store_pos_ff) >= 32'(disp_ff)) begin
         slot = micv_pkg::STORE_BITS'(32'(store_pos_ff) - 32'(disp_ff));
      end else begin
         slot = micv_pkg::STORE_BITS'(32'(store_pos_ff) + micv_pkg::STORE_DEPTH -
                                      32'(disp_ff));
      end
   end

   assign ls_rd_en  = (state_ff == ST_LREAD);
   assign tbl_rd_en = (state_ff == ST_TREAD);

   // red, green, blue in that order, MSB first in both store words
   always_comb begin
      for (int c = 0; c < micv_pkg::TABLE_COUNT; c++) begin
         tbl_rd_addr[c] = {ls_rd_data[(2-c)*LB +: LB], left_ff[(2-c)*LB +: LB]};
      end
   end

   assign score_sum = micv_pkg::SUM_BITS'(tbl_rd_data[0]) +
                      micv_pkg::SUM_BITS'(tbl_rd_data[1]) +
                      micv_pkg::SUM_BITS'(tbl_rd_data[2]);
   assign scaled    = micv_pkg::SHIFT_BITS'(product_ff >> micv_pkg::SCORE_FRAC_BITS);
   assign cost_sat  = (32'(scaled) > micv_pkg::COST_MAX) ?
                      micv_pkg::COST_BITS'(micv_pkg::COST_MAX) :
                      micv_pkg::COST_BITS'(scaled);

   micv_ram #(
      .WIDTH (micv_pkg::STORE_WIDTH),
      .DEPTH (micv_pkg::STORE_DEPTH)
   ) u_line_store (
      .clock   (clock),
      .wr_en   (ls_wr_en),
      .wr_addr (store_pos_ff),
      .wr_data (ls_wr_data),
      .rd_en   (ls_rd_en),
      .rd_addr (slot),
      .rd_data (ls_rd_data)
   );

   for (genvar g = 0; g < micv_pkg::TABLE_COUNT; g++) begin : g_table
      micv_ram #(
         .WIDTH (micv_pkg::SCORE_BITS),
         .DEPTH (micv_pkg::TABLE_DEPTH)
      ) u_score_table (
         .clock   (clock),
         .wr_en   (tbl_wr_en[g]),
         .wr_addr (tbl_wr_addr),
         .wr_data (req_data.score_value),
         .rd_en   (tbl_rd_en),
         .rd_addr (tbl_rd_addr[g]),
         .rd_data (tbl_rd_data[g])
      );
   end

   always_comb begin
      state_in         = state_ff;
      max_disparity_in = max_disparity_ff;
      border_cost_in   = border_cost_ff;
      disp_in          = disp_ff;
      maxd_in          = maxd_ff;
      x_in             = x_ff;
      col_count_in     = col_count_ff;
      store_pos_in     = store_pos_ff;
      left_in          = left_ff;
      product_in       = product_ff;
      rsp_data_in      = rsp_data_ff;

      if (csr_wr_en) begin
         unique case (csr_index)
            micv_pkg::CSR_MAX_DISPARITY: begin
               max_disparity_in = micv_pkg::DISP_BITS'(csr_wr_data);
            end
            micv_pkg::CSR_BORDER_COST: begin
               border_cost_in = micv_pkg::COST_BITS'(csr_wr_data);
            end
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (ls_wr_en) begin
               disp_in = '0;
               if (32'(max_disparity_ff) > micv_pkg::MAX_DISP) begin
                  maxd_in = micv_pkg::DISP_BITS'(micv_pkg::MAX_DISP);
               end else begin
                  maxd_in = max_disparity_ff;
               end
               x_in = col_start;
               if (32'(col_start) < micv_pkg::STORE_DEPTH) begin
                  col_count_in = col_start + 1'b1;
               end else begin
                  col_count_in = col_start;
               end
               left_in = {micv_pkg::clamp_level(req_data.left_red),
                          micv_pkg::clamp_level(req_data.left_green),
                          micv_pkg::clamp_level(req_data.left_blue)};
               state_in = ST_LREAD;
            end
         end
         ST_LREAD: begin
            rsp_data_in.disparity     = disp_ff;
            rsp_data_in.last_of_pixel = (disp_ff == maxd_ff);
            if (32'(disp_ff) > 32'(x_ff)) begin
               rsp_data_in.cost = border_cost_ff;
               state_in         = ST_OUT;
            end else begin
               state_in = ST_TREAD;
            end
         end
         ST_TREAD: begin
            state_in = ST_MUL;
         end
         ST_MUL: begin
            product_in = micv_pkg::PROD_BITS'(score_sum) *
                         micv_pkg::PROD_BITS'(micv_pkg::COST_SCALE);
            state_in   = ST_SAT;
         end
         ST_SAT: begin
            rsp_data_in.cost = cost_sat;
            state_in         = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_accept) begin
               if (disp_ff == maxd_ff) begin
                  if (32'(store_pos_ff) == micv_pkg::STORE_DEPTH - 1) begin
                     store_pos_in = '0;
                  end else begin
                     store_pos_in = store_pos_ff + 1'b1;
                  end
                  state_in = ST_IDLE;
               end else begin
                  disp_in  = disp_ff + 1'b1;
                  state_in = ST_LREAD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         max_disparity_ff <= micv_pkg::DISP_BITS'(63);
         border_cost_ff   <= '0;
         col_count_ff     <= '0;
         store_pos_ff     <= '0;
      end else begin
         state_ff         <= state_in;
         max_disparity_ff <= max_disparity_in;
         border_cost_ff   <= border_cost_in;
         col_count_ff     <= col_count_in;
         store_pos_ff     <= store_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      disp_ff     <= disp_in;
      maxd_ff     <= maxd_in;
      x_ff        <= x_in;
      left_ff     <= left_in;
      product_ff  <= product_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a cost is pending");

   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_accept && rsp_data.last_of_pixel |=> req_ready)
      else $error("not idle after last cost of pixel");

   a_disp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.disparity <= maxd_ff))
      else $error("disparity beyond limit");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.last_of_pixel == (rsp_data.disparity == maxd_ff)))
      else $error("last flag mismatch");

endmodule

### rtl/micv_ram.sv
module micv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam int          SETTLE_CYCLES = 20;
   localparam int unsigned CYCLE_LIMIT   = 8000000;
   localparam int          REPORT_CAP    = 100;
   localparam int          PHASE_ITEMS   = 55;
   localparam int          LEVEL_COUNT   = 6;

   logic                                clock       = 1'b0;
   logic                                reset       = 1'b1;
   logic                                req_valid   = 1'b0;
   logic                                req_ready;
   micv_pkg::req_type                   req_data    = '0;
   logic                                rsp_valid;
   logic                                rsp_ready   = 1'b0;
   micv_pkg::rsp_type                   rsp_data;
   logic                                csr_wr_en   = 1'b0;
   logic [micv_pkg::CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [micv_pkg::CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   mutual_info_cost_volume_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // shadow of the block
   bit [micv_pkg::SCORE_BITS-1:0] score_model [3][micv_pkg::TABLE_DEPTH];
   bit [7:0]                      line_model [micv_pkg::STORE_DEPTH][3];
   bit [micv_pkg::STORE_BITS-1:0] line_pos    = '0;
   int                            column_fill = 0;
   bit [5:0]                      cfg_max_disp = 6'd63;
   bit [15:0]                     cfg_border   = 16'd0;

   micv_pkg::req_type pending_items [$];
   micv_pkg::rsp_type expected_costs [$];
   logic [7:0]        known_levels [LEVEL_COUNT];
   int                error_count = 0;
   int unsigned       cycle_count = 0;
   int                req_gap     = 0;
   int                rsp_hold    = 0;
   bit                req_burst   = 1'b0;
   bit                rsp_burst   = 1'b0;

   function automatic void predict_costs(input micv_pkg::req_type item);
      logic [7:0]                    left_px [3];
      bit [micv_pkg::STORE_BITS-1:0] slot;
      longint                        sum;
      longint                        scaled;
      micv_pkg::rsp_type             want;
      if (item.func == micv_pkg::FUNC_TABLE_WRITE) begin
         if (item.table_channel != 2'd3) begin
            score_model[item.table_channel][{item.table_right_level, item.table_left_level}]
               = item.score_value;
         end
         return;
      end
      if (item.row_start) begin
         column_fill = 0;
      end
      left_px[0] = item.left_red;
      left_px[1] = item.left_green;
      left_px[2] = item.left_blue;
      line_model[line_pos][0] = item.right_red;
      line_model[line_pos][1] = item.right_green;
      line_model[line_pos][2] = item.right_blue;
      for (int d = 0; d <= int'(cfg_max_disp); d++) begin
         if (d > column_fill) begin
            want.cost = cfg_border;
         end else begin
            slot = line_pos - micv_pkg::STORE_BITS'(d);
            sum  = 0;
            for (int c = 0; c < 3; c++) begin
               sum += score_model[c][{line_model[slot][c], left_px[c]}];
            end
            scaled = (sum * micv_pkg::COST_SCALE) >>> micv_pkg::SCORE_FRAC_BITS;
            if (scaled > micv_pkg::COST_MAX) begin
               scaled = micv_pkg::COST_MAX;
            end
            want.cost = micv_pkg::COST_BITS'(scaled);
         end
         want.disparity     = micv_pkg::DISP_BITS'(d);
         want.last_of_pixel = (d == int'(cfg_max_disp));
         expected_costs.push_back(want);
      end
      line_pos = line_pos + 1'b1;
      if (column_fill < micv_pkg::STORE_DEPTH) begin
         column_fill++;
      end
   endfunction

   function automatic int draw_gap(input bit burst);
      int r;
      r = $urandom_range(0, 99);
      if (burst || r < 65) begin
         return 0;
      end else if (r < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(15, 50);
   endfunction

   function automatic logic [micv_pkg::SCORE_BITS-1:0] draw_score();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) begin
         return '1;
      end else if (r < 10) begin
         return '0;
      end else if (r < 35) begin
         return micv_pkg::SCORE_BITS'($urandom);
      end
      return micv_pkg::SCORE_BITS'($urandom_range(0, 16000));
   endfunction

   function automatic logic [7:0] pick_level();
      return known_levels[$urandom_range(0, LEVEL_COUNT - 1)];
   endfunction

   // unused fields carry random bits
   function automatic micv_pkg::req_type make_score_write(
         input logic [1:0] ch, input logic [7:0] rl, input logic [7:0] ll,
         input logic [micv_pkg::SCORE_BITS-1:0] score);
      logic [95:0]       noise;
      micv_pkg::req_type item;
      noise                  = {$urandom, $urandom, $urandom};
      item                   = noise[$bits(micv_pkg::req_type)-1:0];
      item.func              = micv_pkg::FUNC_TABLE_WRITE;
      item.table_channel     = ch;
      item.table_right_level = rl;
      item.table_left_level  = ll;
      item.score_value       = score;
      return item;
   endfunction

   function automatic micv_pkg::req_type make_pixel(input bit start, input logic [7:0] lr,
                                                    input logic [7:0] lg, input logic [7:0] lb,
                                                    input logic [7:0] rr, input logic [7:0] rg,
                                                    input logic [7:0] rb);
      logic [95:0]       noise;
      micv_pkg::req_type item;
      noise            = {$urandom, $urandom, $urandom};
      item             = noise[$bits(micv_pkg::req_type)-1:0];
      item.func        = micv_pkg::FUNC_PIXEL;
      item.left_red    = lr;
      item.left_green  = lg;
      item.left_blue   = lb;
      item.right_red   = rr;
      item.right_green = rg;
      item.right_blue  = rb;
      item.row_start   = start;
      return item;
   endfunction

   task automatic drain();
      while (pending_items.size() != 0 || req_valid || expected_costs.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [micv_pkg::CSR_INDEX_BITS-1:0] idx,
                                 input logic [micv_pkg::CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= value;
      if (idx == micv_pkg::CSR_MAX_DISPARITY) begin
         cfg_max_disp = value[5:0];
      end else begin
         cfg_border = value;
      end
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mostly scanlines with random content, some table updates and stray writes
   task automatic queue_random_phase(input int count, inout int row_left);
      int pick;
      bit start;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            start = 1'b0;
            if (row_left == 0) begin
               pick = $urandom_range(0, 99);
               row_left = (pick < 70) ? $urandom_range(1, 12) :
                          (pick < 95) ? $urandom_range(13, 70) : $urandom_range(65, 90);
               start = 1'b1;
            end
            if ($urandom_range(0, 49) == 0) begin
               start = 1'b1;
            end
            row_left--;
            pending_items.push_back(make_pixel(start, pick_level(), pick_level(), pick_level(),
                                               pick_level(), pick_level(), pick_level()));
         end else if (pick < 92) begin
            pending_items.push_back(make_score_write(2'($urandom_range(0, 2)), pick_level(),
                                                     pick_level(), draw_score()));
         end else if (pick < 96) begin
            pending_items.push_back(make_score_write(2'd3, pick_level(), pick_level(),
                                                     micv_pkg::SCORE_BITS'($urandom)));
         end else begin
            pending_items.push_back(make_score_write(2'($urandom_range(0, 3)), 8'($urandom),
                                                     8'($urandom),
                                                     micv_pkg::SCORE_BITS'($urandom)));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_costs(req_data);
         end
         if (req_valid && !req_ready) begin
            req_valid <= 1'b1;
         end else if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_items.size() != 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_items.pop_front();
            req_gap   <= draw_gap(req_burst);
         end else begin
            req_valid <= 1'b0;
         end
         if ($urandom_range(0, 199) == 0) begin
            req_burst <= ~req_burst;
         end
      end
   end

   task automatic note_mismatch(input string field, input int want, input int got);
      if (error_count < REPORT_CAP) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      end
      error_count++;
   endtask

   always @(posedge clock) begin
      micv_pkg::rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_costs.size() == 0) begin
               note_mismatch("unexpected cost item, cost", -1, rsp_data.cost);
            end else begin
               want = expected_costs.pop_front();
               if (rsp_data.cost !== want.cost) begin
                  note_mismatch("cost", want.cost, rsp_data.cost);
               end
               if (rsp_data.disparity !== want.disparity) begin
                  note_mismatch("disparity", want.disparity, rsp_data.disparity);
               end
               if (rsp_data.last_of_pixel !== want.last_of_pixel) begin
                  note_mismatch("last_of_pixel", want.last_of_pixel, rsp_data.last_of_pixel);
               end
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold  <= rsp_hold - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            rsp_hold  <= draw_gap(rsp_burst);
         end
         if ($urandom_range(0, 299) == 0) begin
            rsp_burst <= ~rsp_burst;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d cost items outstanding", $time,
                  expected_costs.size());
         $display("mutual_info_cost_volume_core regression: fail");
         $finish;
      end
   end

   initial begin
      int          row_left;
      logic [5:0]  disp_plan [6];
      logic [15:0] border_plan [6];
      row_left    = 0;
      disp_plan   = '{6'd0, 6'd63, 6'd5, 6'd1, 6'd17, 6'd63};
      border_plan = '{16'hFFFF, 16'hFFFF, 16'($urandom), 16'h0000, 16'($urandom),
                      16'($urandom)};
      known_levels = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'($urandom), 8'($urandom)};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // every level pair that a pixel may use gets a score first
      for (int c = 0; c < 3; c++) begin
         for (int r = 0; r < LEVEL_COUNT; r++) begin
            for (int l = 0; l < LEVEL_COUNT; l++) begin
               pending_items.push_back(make_score_write(2'(c), known_levels[r],
                                                        known_levels[l], draw_score()));
            end
         end
      end

      // columns counted from reset, no row start yet
      pending_items.push_back(make_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      pending_items.push_back(make_pixel(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00));
      for (int c = 0; c < 3; c++) begin
         pending_items.push_back(make_score_write(2'(c), 8'hFF, 8'hFF, '1));
         pending_items.push_back(make_score_write(2'(c), 8'h00, 8'h00, '0));
      end
      // no fourth table: must leave the zero entries alone
      pending_items.push_back(make_score_write(2'd3, 8'h00, 8'h00, '1));
      pending_items.push_back(make_pixel(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      pending_items.push_back(make_pixel(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      pending_items.push_back(make_pixel(1'b0, 8'hFF, 8'h00, 8'hFF, 8'h55, 8'hAA, 8'h55));
      pending_items.push_back(make_score_write(2'd1, 8'h55, 8'hAA, 17'h0AAAA));
      pending_items.push_back(make_score_write(2'd2, 8'hAA, 8'h55, 17'h15555));
      pending_items.push_back(make_pixel(1'b0, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA));
      pending_items.push_back(make_pixel(1'b1, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55));
      drain();

      for (int p = 0; p < 6; p++) begin
         write_register(micv_pkg::CSR_MAX_DISPARITY, {10'($urandom), disp_plan[p]});
         write_register(micv_pkg::CSR_BORDER_COST, border_plan[p]);
         queue_random_phase(PHASE_ITEMS, row_left);
         drain();
      end

      if (error_count == 0) begin
         $display("mutual_info_cost_volume_core regression: pass");
      end else begin
         $display("mutual_info_cost_volume_core regression: fail");
      end
      $finish;
   end

endmodule
